// ===== hw/rtl/svt_pkg.sv =====
// svt_pkg: shared types, codes and sizes for the sorted value table.
// Used by svt_cell, sorted_value_table, svt_checker and the testbench; no dependencies.

package svt_pkg;

    localparam int VAL_W        = 32;
    localparam int CMD_W        = 2;
    localparam int STAT_W       = 2;
    localparam int ECNT_W       = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // broadcast update strobes, already qualified by transfer and status
    typedef struct packed {
        logic ins;
        logic rem;
        logic clr;
    } svt_op_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic             valid;
        logic             lt;     // stored value is below the search value
        logic [VAL_W-1:0] val;
    } svt_nbr_t;

endpackage

// ===== hw/rtl/svt_cell.sv =====
// svt_cell: one slot of the sorted table, holding a value and a valid bit.
// Compares against the broadcast value and shifts toward either neighbor.
// Depends on svt_pkg.

module svt_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  svt_pkg::svt_op_t               op,
    input  logic signed [svt_pkg::VAL_W-1:0] x,
    input  svt_pkg::svt_nbr_t              prev_in,   // lower-index neighbor
    input  svt_pkg::svt_nbr_t              next_in,   // higher-index neighbor
    output svt_pkg::svt_nbr_t              cell_out,
    output logic                           eq
);

    logic                      valid_reg, valid_next;
    logic [svt_pkg::VAL_W-1:0] val_reg, val_next;
    logic                      lt;

    assign lt       = valid_reg && (x > $signed(val_reg));
    assign eq       = valid_reg && ($signed(val_reg) == x);
    assign cell_out = '{valid: valid_reg, lt: lt, val: val_reg};

    always_comb begin
        valid_next = valid_reg;
        val_next   = val_reg;
        if (op.clr) begin
            valid_next = 1'b0;
        end else if (op.ins && !lt) begin
            // first slot not below x takes x, the rest move up by one
            if (prev_in.lt) begin
                val_next   = x;
                valid_next = 1'b1;
            end else begin
                val_next   = prev_in.val;
                valid_next = prev_in.valid;
            end
        end else if (op.rem && !lt) begin
            // slots from the first equal onward move down by one
            val_next   = next_in.val;
            valid_next = next_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// ===== hw/rtl/sorted_value_table.sv =====
// Sorted value table: a chain of CAPACITY cells kept in ascending order.
// Result: registered, on m_* in the cycle after its input transfer.
// Throughput: one item per cycle unless stalled; every cell updates in the
// same cycle, bounded by the compare plus the equal-match OR across the chain.
// Reset: valid bits and entry count cleared at once, no clearing pass;
// the output register is emptied.

module sorted_value_table #(
    parameter int CAPACITY = svt_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [6:2] entry_count, [7] zero
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    svt_pkg::svt_nbr_t    cell_w [CAPACITY];
    logic [CAPACITY-1:0]  eq_w;
    svt_pkg::svt_op_t     op;
    logic                 xfer, full, found;
    logic signed [svt_pkg::VAL_W-1:0] x;
    logic [svt_pkg::CMD_W-1:0]        cmd;

    logic                       out_valid_reg, out_valid_next;
    logic [svt_pkg::STAT_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W+svt_pkg::ECNT_W-1:0] count_ext;

    assign x        = $signed(s_tdata);
    assign cmd      = s_tuser;
    assign s_tready = !out_valid_reg || m_tready;
    assign xfer     = s_tvalid && s_tready;
    assign full     = cell_w[CAPACITY-1].valid;
    assign found    = |eq_w;

    assign op.ins = xfer && (cmd == svt_pkg::CMD_INSERT) && !full;
    assign op.rem = xfer && (cmd == svt_pkg::CMD_REMOVE) && found;
    assign op.clr = xfer && (cmd == svt_pkg::CMD_CLEAR);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        svt_pkg::svt_nbr_t prev_n, next_n;
        if (i == 0) begin : g_first
            assign prev_n = '{valid: 1'b0, lt: 1'b1, val: '0};
        end else begin : g_mid_lo
            assign prev_n = cell_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_n = '{valid: 1'b0, lt: 1'b0, val: '0};
        end else begin : g_mid_hi
            assign next_n = cell_w[i+1];
        end
        svt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .op       (op),
            .x        (x),
            .prev_in  (prev_n),
            .next_in  (next_n),
            .cell_out (cell_w[i]),
            .eq       (eq_w[i])
        );
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (xfer) begin
            out_valid_next = 1'b1;
            status_next    = svt_pkg::ST_DONE;
            unique case (cmd)
                svt_pkg::CMD_INSERT: begin
                    if (full) begin
                        status_next = svt_pkg::ST_FULL;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                svt_pkg::CMD_REMOVE: begin
                    if (found) begin
                        count_next = count_reg - 1'b1;
                    end else begin
                        status_next = svt_pkg::ST_ABSENT;
                    end
                end
                svt_pkg::CMD_SEARCH: begin
                    if (!found) begin
                        status_next = svt_pkg::ST_ABSENT;
                    end
                end
                svt_pkg::CMD_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    status_next = svt_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

    // count is masked to the 5-bit field
    assign count_ext = {{svt_pkg::ECNT_W{1'b0}}, count_reg};
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, count_ext[svt_pkg::ECNT_W-1:0], status_reg};

endmodule

// ===== hw/rtl/svt_checker.sv =====
// svt_checker: port-level checks on the sorted value table, bound to the top.
// Depends on svt_pkg and the sorted_value_table port list.

module svt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result one cycle after input transfer");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == svt_pkg::CMD_CLEAR) |=>
        (m_tdata[1:0] == svt_pkg::ST_DONE) && (m_tdata[6:2] == 5'd0))
        else $error("clear did not report an empty table");

endmodule

bind sorted_value_table svt_checker u_svt_checker (.*);

// ===== sim/tb_sorted_value_table.sv =====
// Self-checking testbench for sorted_value_table: directed table, then random traffic.
// Depends on svt_pkg and the sorted_value_table RTL; nothing else.

module tb_sorted_value_table;

    localparam int TB_CAP     = svt_pkg::CAPACITY_DEF;
    localparam int CNT_FW     = svt_pkg::ECNT_W;
    localparam int N_RANDOM   = 650;
    localparam int WATCHDOG   = 5000;
    localparam int DRAIN_WAIT = 4;

    typedef struct packed {
        logic [svt_pkg::STAT_W-1:0] status;
        logic [svt_pkg::ECNT_W-1:0] count;
    } lookup_result_t;

    typedef struct {
        logic [svt_pkg::CMD_W-1:0] cmd;
        logic [svt_pkg::VAL_W-1:0] value;
        bit                        typed;
        lookup_result_t            res;
    } stim_row_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;
    logic [1:0]        s_tuser  = svt_pkg::CMD_SEARCH;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;

    // model state: stored values, smallest first
    logic signed [svt_pkg::VAL_W-1:0] sorted_q[$];
    lookup_result_t                   pending_results[$];
    stim_row_t                        dir_rows[$];

    int errors       = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    int n_checked    = 0;
    int n_full       = 0;
    int n_absent     = 0;
    int n_by_cmd[4]  = '{0, 0, 0, 0};
    int stall_mode   = 0;
    int stall_left   = 0;
    int stall_tick   = 0;

    sorted_value_table #(.CAPACITY(TB_CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tuser  (s_tuser),   // [1:0] command
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [1:0] status, [6:2] entry_count, [7] zero
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic lookup_result_t apply_table_op(
        input logic [svt_pkg::CMD_W-1:0]        cmd,
        input logic signed [svt_pkg::VAL_W-1:0] v);
        lookup_result_t r;
        int pos;
        r.status = svt_pkg::ST_DONE;
        pos = 0;
        case (cmd)
            svt_pkg::CMD_INSERT: begin
                if (sorted_q.size() >= TB_CAP) begin
                    r.status = svt_pkg::ST_FULL;
                end else begin
                    // new duplicate lands ahead of its equals
                    while (pos < sorted_q.size() && v > sorted_q[pos]) pos++;
                    sorted_q.insert(pos, v);
                end
            end
            svt_pkg::CMD_REMOVE, svt_pkg::CMD_SEARCH: begin
                while (pos < sorted_q.size() && sorted_q[pos] != v) pos++;
                if (pos >= sorted_q.size())
                    r.status = svt_pkg::ST_ABSENT;
                else if (cmd == svt_pkg::CMD_REMOVE)
                    sorted_q.delete(pos);
            end
            default: sorted_q.delete();
        endcase
        r.count = CNT_FW'(sorted_q.size());
        return r;
    endfunction

    function automatic void add_row(input logic [svt_pkg::CMD_W-1:0] cmd,
                                    input logic [svt_pkg::VAL_W-1:0] v,
                                    input bit typed = 1'b0,
                                    input logic [svt_pkg::STAT_W-1:0] st = svt_pkg::ST_DONE,
                                    input logic [svt_pkg::ECNT_W-1:0] cnt = '0);
        stim_row_t row;
        row.cmd   = cmd;
        row.value = v;
        row.typed = typed;
        row.res   = '{status: st, count: cnt};
        dir_rows.push_back(row);
    endfunction

    // Drive one item; sender may idle for a random gap between bursts of random length.
    task automatic send_item(input logic [svt_pkg::CMD_W-1:0] cmd,
                             input logic [svt_pkg::VAL_W-1:0] v,
                             input bit typed, input lookup_result_t typed_res);
        int gap;
        lookup_result_t pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        pred = apply_table_op(cmd, v);
        n_by_cmd[cmd]++;
        if (pred.status == svt_pkg::ST_FULL)   n_full++;
        if (pred.status == svt_pkg::ST_ABSENT) n_absent++;
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // Receiver: stall pattern switches between a few modes.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 150);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= stall_tick[2];
        endcase
    end

    // Result checker
    always @(posedge aclk) begin
        lookup_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending: tdata %h", $time, m_tdata);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (m_tdata[1:0] !== exp_r.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_r.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[6:2] !== exp_r.count) begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, exp_r.count, m_tdata[6:2]);
                    errors++;
                end
                if (m_tdata[7] !== 1'b0) begin
                    $display("%0t: pad bit mismatch: expected 0, actual %b", $time, m_tdata[7]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("%0t: no transfer for %0d cycles, %0d results pending",
                     $time, WATCHDOG, pending_results.size());
            $display("tb_sorted_value_table: done, errors");
            $finish;
        end
    end

    initial begin
        int r;
        logic [svt_pkg::CMD_W-1:0] cmd;
        logic [svt_pkg::VAL_W-1:0] v;

        // empty table
        add_row(svt_pkg::CMD_SEARCH, 32'h0000_0000, 1'b1, svt_pkg::ST_ABSENT, 5'd0);
        add_row(svt_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 1'b1, svt_pkg::ST_ABSENT, 5'd0);
        // extremes, duplicates, first-equal removal
        add_row(svt_pkg::CMD_INSERT, 32'h8000_0000);
        add_row(svt_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        add_row(svt_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        add_row(svt_pkg::CMD_SEARCH, 32'h8000_0000);
        add_row(svt_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        add_row(svt_pkg::CMD_REMOVE, 32'h7FFF_FFFF);
        add_row(svt_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 1'b1, svt_pkg::ST_DONE, 5'd0);
        // fill to capacity with assorted bit patterns, then overflow
        add_row(svt_pkg::CMD_INSERT, 32'h0000_0000);
        add_row(svt_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        add_row(svt_pkg::CMD_INSERT, 32'h0000_0001);
        add_row(svt_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        add_row(svt_pkg::CMD_INSERT, 32'h5555_5555);
        add_row(svt_pkg::CMD_INSERT, 32'h8000_0000);
        add_row(svt_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        add_row(svt_pkg::CMD_INSERT, 32'h1234_5678);
        add_row(svt_pkg::CMD_INSERT, 32'h8765_4321);
        add_row(svt_pkg::CMD_INSERT, 32'h0000_0000);
        add_row(svt_pkg::CMD_INSERT, 32'hFFFF_0000);
        add_row(svt_pkg::CMD_INSERT, 32'h0000_FFFF);
        add_row(svt_pkg::CMD_INSERT, 32'h8000_0001);
        add_row(svt_pkg::CMD_INSERT, 32'h7FFF_FFFE);
        add_row(svt_pkg::CMD_INSERT, 32'hDEAD_BEEF);
        add_row(svt_pkg::CMD_INSERT, 32'h0000_0002);
        add_row(svt_pkg::CMD_INSERT, 32'h0000_0005, 1'b1, svt_pkg::ST_FULL, 5'(TB_CAP));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[j])
            send_item(dir_rows[j].cmd, dir_rows[j].value, dir_rows[j].typed, dir_rows[j].res);

        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 42)      cmd = svt_pkg::CMD_INSERT;
            else if (r < 72) cmd = svt_pkg::CMD_REMOVE;
            else if (r < 95) cmd = svt_pkg::CMD_SEARCH;
            else             cmd = svt_pkg::CMD_CLEAR;
            // mostly values already stored, so removes and searches hit
            r = $urandom_range(0, 99);
            if (sorted_q.size() != 0 && r < 55) begin
                v = sorted_q[$urandom_range(0, sorted_q.size() - 1)];
            end else if (r < 65) begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end else begin
                v = $urandom;
            end
            send_item(cmd, v, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d inserts, %0d removes, %0d searches, %0d clears",
                 n_by_cmd[svt_pkg::CMD_INSERT], n_by_cmd[svt_pkg::CMD_REMOVE],
                 n_by_cmd[svt_pkg::CMD_SEARCH], n_by_cmd[svt_pkg::CMD_CLEAR]);
        $display("%0d results checked; refused on full table %0d times, not present %0d times",
                 n_checked, n_full, n_absent);
        if (errors == 0)
            $display("tb_sorted_value_table: done, clean");
        else
            $display("tb_sorted_value_table: done, errors");
        $finish;
    end

endmodule
